// File: rtl/core/bq_pkg.sv
// Package for the biquad IIR section: widths, request/response structs,
// register indexes and the microcode table of the sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bq_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_WIDTH     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int HISTORY_WIDTH  = 24;
   localparam int NUM_COEFS      = 5;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int PROD_WIDTH     = COEF_WIDTH + HISTORY_WIDTH;
   localparam int RND_WIDTH      = PROD_WIDTH - COEF_FRAC_BITS;
   localparam int ACC_WIDTH      = RND_WIDTH + 2;
   localparam int STEP_WIDTH     = 3;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic                           clear_history;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           clipped;
   } rsp_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_FB_COEF_1 = 3'd0,
      CSR_FB_COEF_2 = 3'd1,
      CSR_FF_COEF_0 = 3'd2,
      CSR_FF_COEF_1 = 3'd3,
      CSR_FF_COEF_2 = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      OPND_H1 = 2'd0,
      OPND_H2 = 2'd1,
      OPND_W  = 2'd2
   } opnd_type;

   typedef enum logic [1:0] {
      ACC_HOLD      = 2'd0,
      ACC_LOAD_X    = 2'd1,
      ACC_LOAD_PROD = 2'd2,
      ACC_ADD       = 2'd3
   } acc_op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS   = 2'd0,
      COND_REQ      = 2'd1,
      COND_OUT_FREE = 2'd2
   } cond_type;

   typedef enum logic [STEP_WIDTH-1:0] {
      STEP_IDLE     = 3'd0,
      STEP_MUL_FB1  = 3'd1,
      STEP_MUL_FB2  = 3'd2,
      STEP_SAT_W    = 3'd3,
      STEP_MUL_FF0  = 3'd4,
      STEP_MUL_FF2  = 3'd5,
      STEP_FINISH   = 3'd6
   } step_type;

   typedef struct packed {
      cond_type      cond;
      step_type      target;
      logic          mul_en;
      csr_index_type coef_sel;
      opnd_type      opnd;
      acc_op_type    acc_op;
      logic          sat_w;
      logic          finish;
   } ctrl_type;

   function automatic ctrl_type bq_rom(input logic [STEP_WIDTH-1:0] step);
      ctrl_type c;
      c = '{cond: COND_ALWAYS, target: STEP_IDLE, mul_en: 1'b0, coef_sel: CSR_FB_COEF_1,
            opnd: OPND_H1, acc_op: ACC_HOLD, sat_w: 1'b0, finish: 1'b0};
      unique case (step)
         STEP_IDLE: begin
            c.cond   = COND_REQ;
            c.target = STEP_MUL_FB1;
            c.acc_op = ACC_LOAD_X;
         end
         STEP_MUL_FB1: begin
            c.target   = STEP_MUL_FB2;
            c.mul_en   = 1'b1;
            c.coef_sel = CSR_FB_COEF_1;
            c.opnd     = OPND_H1;
         end
         STEP_MUL_FB2: begin
            c.target   = STEP_SAT_W;
            c.mul_en   = 1'b1;
            c.coef_sel = CSR_FB_COEF_2;
            c.opnd     = OPND_H2;
            c.acc_op   = ACC_ADD;
         end
         STEP_SAT_W: begin
            c.target   = STEP_MUL_FF0;
            c.mul_en   = 1'b1;
            c.coef_sel = CSR_FF_COEF_1;
            c.opnd     = OPND_H1;
            c.sat_w    = 1'b1;
         end
         STEP_MUL_FF0: begin
            c.target   = STEP_MUL_FF2;
            c.mul_en   = 1'b1;
            c.coef_sel = CSR_FF_COEF_0;
            c.opnd     = OPND_W;
            c.acc_op   = ACC_LOAD_PROD;
         end
         STEP_MUL_FF2: begin
            c.target   = STEP_FINISH;
            c.mul_en   = 1'b1;
            c.coef_sel = CSR_FF_COEF_2;
            c.opnd     = OPND_H2;
            c.acc_op   = ACC_ADD;
         end
         STEP_FINISH: begin
            c.cond   = COND_OUT_FREE;
            c.target = STEP_IDLE;
            c.finish = 1'b1;
         end
         default: begin
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/biquad_iir_filter.sv
// Biquad IIR section, direct form II, microcoded around one shared multiplier.
// Requests are taken only in STEP_IDLE, so no new one enters until the last is done.
// The steps MUL_FB1, MUL_FB2, SAT_W, MUL_FF0 and MUL_FF2 pass the five products one at
// a time through the single multiplier; FINISH waits while rsp_ready holds an earlier response.
// Synchronous active-high reset: coefficients to 0 except ff_coef_0 = 1.0,
// history cleared, sequencer idle. Depends on bq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire bq_pkg::req_type                     req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output bq_pkg::rsp_type                          rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bq_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [bq_pkg::COEF_WIDTH-1:0]       csr_data
);
   import bq_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] HIST_MAX = ACC_WIDTH'((2 ** (HISTORY_WIDTH - 1)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] HIST_MIN = -HIST_MAX - ACC_WIDTH'(1);
   localparam logic signed [ACC_WIDTH-1:0] SAMP_MAX = ACC_WIDTH'((2 ** (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] SAMP_MIN = -SAMP_MAX - ACC_WIDTH'(1);
   localparam logic [PROD_WIDTH-1:0]       RND_HALF = PROD_WIDTH'(2 ** (COEF_FRAC_BITS - 1));
   localparam logic [CSR_IDX_WIDTH-1:0]    CSR_LIMIT = CSR_IDX_WIDTH'(NUM_COEFS);
   localparam logic [COEF_WIDTH-1:0]       COEF_ONE = COEF_WIDTH'(2 ** COEF_FRAC_BITS);

   logic [STEP_WIDTH-1:0]          step_ff, step_in;
   logic [COEF_WIDTH-1:0]          coef_ff [NUM_COEFS];
   logic signed [HISTORY_WIDTH-1:0] h1_ff, h2_ff, w_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic signed [ACC_WIDTH-1:0]    acc_ff;
   logic                           clip_ff;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_ff;

   ctrl_type                       ctrl;
   logic                           cond_ok;
   logic                           req_fire;
   logic                           out_free;
   logic signed [COEF_WIDTH-1:0]   coef_mux;
   logic signed [HISTORY_WIDTH-1:0] opnd_mux;
   logic signed [PROD_WIDTH-1:0]   mul_res;
   logic [PROD_WIDTH-1:0]          rnd_full;
   logic signed [RND_WIDTH-1:0]    rnd_val;
   logic signed [ACC_WIDTH-1:0]    acc_sum;
   logic signed [HISTORY_WIDTH-1:0] w_sat;
   logic                           w_clip;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;
   logic                           y_clip;

   assign ctrl      = bq_rom(step_ff);
   assign req_ready = (step_ff == STEP_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      unique case (ctrl.cond)
         COND_REQ:      cond_ok = req_fire;
         COND_OUT_FREE: cond_ok = out_free;
         default:       cond_ok = 1'b1;
      endcase
      step_in = cond_ok ? ctrl.target : step_ff;
   end

   always_comb begin
      coef_mux = $signed(coef_ff[ctrl.coef_sel]);
      unique case (ctrl.opnd)
         OPND_H2: opnd_mux = h2_ff;
         OPND_W:  opnd_mux = w_ff;
         default: opnd_mux = h1_ff;
      endcase
   end

   assign mul_res  = PROD_WIDTH'(coef_mux) * PROD_WIDTH'(opnd_mux);
   assign rnd_full = prod_ff + RND_HALF;
   assign rnd_val  = rnd_full[PROD_WIDTH-1:COEF_FRAC_BITS];
   assign acc_sum  = acc_ff + ACC_WIDTH'(rnd_val);

   always_comb begin
      w_clip = 1'b1;
      priority if (acc_sum > HIST_MAX) begin
         w_sat = HIST_MAX[HISTORY_WIDTH-1:0];
      end else if (acc_sum < HIST_MIN) begin
         w_sat = HIST_MIN[HISTORY_WIDTH-1:0];
      end else begin
         w_sat  = acc_sum[HISTORY_WIDTH-1:0];
         w_clip = 1'b0;
      end
      y_clip = 1'b1;
      priority if (acc_sum > SAMP_MAX) begin
         y_sat = SAMP_MAX[SAMPLE_WIDTH-1:0];
      end else if (acc_sum < SAMP_MIN) begin
         y_sat = SAMP_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         y_sat  = acc_sum[SAMPLE_WIDTH-1:0];
         y_clip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= 1'b0;
         h1_ff        <= '0;
         h2_ff        <= '0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= (i == int'(CSR_FF_COEF_0)) ? COEF_ONE : '0;
         end
      end else begin
         step_ff <= step_in;
         if (csr_valid && (csr_index < CSR_LIMIT)) begin
            coef_ff[csr_index] <= csr_data;
         end
         priority if (ctrl.finish && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            clip_ff <= 1'b0;
            if (req_data.clear_history) begin
               h1_ff <= '0;
               h2_ff <= '0;
            end
         end
         if (ctrl.sat_w) begin
            clip_ff <= w_clip;
         end
         if (ctrl.finish && out_free) begin
            h2_ff        <= h1_ff;
            h1_ff        <= w_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= mul_res;
      end
      if (ctrl.sat_w) begin
         w_ff <= w_sat;
      end
      if (ctrl.finish && out_free) begin
         rsp_ff.sample_out <= y_sat;
         rsp_ff.clipped    <= clip_ff | y_clip;
      end
      unique case (ctrl.acc_op)
         ACC_LOAD_X: begin
            if (req_fire) begin
               acc_ff <= ACC_WIDTH'($signed(req_data.sample_in));
            end
         end
         ACC_LOAD_PROD: acc_ff <= ACC_WIDTH'(rnd_val);
         ACC_ADD:       acc_ff <= acc_sum;
         default:       acc_ff <= acc_ff;
      endcase
   end

endmodule

`default_nettype wire
